@@ design/psd_pkg.sv @@
package psd_pkg;
    localparam int TAPS     = 103;
    localparam int PDM_BITS = 64;
    localparam int SINC_LEN = 64;
    localparam int HALF_LEN = 52;
    localparam int FRAC     = 15;
    localparam int ACC_W    = 40;
    localparam int TAP_W    = 7;
    localparam int BIT_W    = 6;

    typedef logic [15:0] t_word;

    function automatic t_word sinc_coef(input logic [BIT_W-1:0] i);
        t_word r;
        case (i)
            6'd0: r = 16'd0;     6'd1: r = 16'd2;     6'd2: r = 16'd9;
            6'd3: r = 16'd21;    6'd4: r = 16'd39;    6'd5: r = 16'd63;
            6'd6: r = 16'd94;    6'd7: r = 16'd132;   6'd8: r = 16'd179;
            6'd9: r = 16'd236;   6'd10: r = 16'd302;  6'd11: r = 16'd379;
            6'd12: r = 16'd467;  6'd13: r = 16'd565;  6'd14: r = 16'd674;
            6'd15: r = 16'd792;  6'd16: r = 16'd920;  6'd17: r = 16'd1055;
            6'd18: r = 16'd1196; 6'd19: r = 16'd1341; 6'd20: r = 16'd1487;
            6'd21: r = 16'd1633; 6'd22: r = 16'd1776; 6'd23: r = 16'd1913;
            6'd24: r = 16'd2042; 6'd25: r = 16'd2159; 6'd26: r = 16'd2263;
            6'd27: r = 16'd2352; 6'd28: r = 16'd2422; 6'd29: r = 16'd2474;
            6'd30: r = 16'd2506; 6'd31: r = 16'd2516; 6'd32: r = 16'd2516;
            6'd33: r = 16'd2506; 6'd34: r = 16'd2474; 6'd35: r = 16'd2422;
            6'd36: r = 16'd2352; 6'd37: r = 16'd2263; 6'd38: r = 16'd2159;
            6'd39: r = 16'd2042; 6'd40: r = 16'd1913; 6'd41: r = 16'd1776;
            6'd42: r = 16'd1633; 6'd43: r = 16'd1487; 6'd44: r = 16'd1341;
            6'd45: r = 16'd1196; 6'd46: r = 16'd1055; 6'd47: r = 16'd920;
            6'd48: r = 16'd792;  6'd49: r = 16'd674;  6'd50: r = 16'd565;
            6'd51: r = 16'd467;  6'd52: r = 16'd379;  6'd53: r = 16'd302;
            6'd54: r = 16'd236;  6'd55: r = 16'd179;  6'd56: r = 16'd132;
            6'd57: r = 16'd94;   6'd58: r = 16'd63;   6'd59: r = 16'd39;
            6'd60: r = 16'd21;   6'd61: r = 16'd9;    6'd62: r = 16'd2;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] fir_half(input logic [5:0] i);
        logic signed [15:0] r;
        case (i)
            6'd0: r = 16'sd176;   6'd1: r = 16'sd29;    6'd2: r = 16'sd28;
            6'd3: r = 16'sd24;    6'd4: r = 16'sd18;    6'd5: r = 16'sd9;
            6'd6: r = -16'sd3;    6'd7: r = -16'sd19;   6'd8: r = -16'sd38;
            6'd9: r = -16'sd61;   6'd10: r = -16'sd87;  6'd11: r = -16'sd115;
            6'd12: r = -16'sd147; 6'd13: r = -16'sd180; 6'd14: r = -16'sd215;
            6'd15: r = -16'sd251; 6'd16: r = -16'sd287; 6'd17: r = -16'sd321;
            6'd18: r = -16'sd354; 6'd19: r = -16'sd383; 6'd20: r = -16'sd408;
            6'd21: r = -16'sd428; 6'd22: r = -16'sd442; 6'd23: r = -16'sd448;
            6'd24: r = -16'sd445; 6'd25: r = -16'sd434; 6'd26: r = -16'sd412;
            6'd27: r = -16'sd379; 6'd28: r = -16'sd336; 6'd29: r = -16'sd282;
            6'd30: r = -16'sd216; 6'd31: r = -16'sd139; 6'd32: r = -16'sd52;
            6'd33: r = 16'sd45;   6'd34: r = 16'sd151;  6'd35: r = 16'sd265;
            6'd36: r = 16'sd385;  6'd37: r = 16'sd510;  6'd38: r = 16'sd637;
            6'd39: r = 16'sd767;  6'd40: r = 16'sd895;  6'd41: r = 16'sd1021;
            6'd42: r = 16'sd1142; 6'd43: r = 16'sd1257; 6'd44: r = 16'sd1363;
            6'd45: r = 16'sd1459; 6'd46: r = 16'sd1544; 6'd47: r = 16'sd1615;
            6'd48: r = 16'sd1671; 6'd49: r = 16'sd1712; 6'd50: r = 16'sd1737;
            default: r = 16'sd1746;
        endcase
        return r;
    endfunction

    // Mirror a tap index onto the half table.
    function automatic logic [5:0] coef_idx(input logic [TAP_W-1:0] k);
        logic [TAP_W-1:0] m;
        logic [TAP_W-1:0] s;
        m = TAP_W'(TAPS - 1) - k;
        s = (k < m) ? k : m;
        if (s >= TAP_W'(HALF_LEN)) s = TAP_W'(HALF_LEN - 1);
        return s[5:0];
    endfunction
endpackage

@@ design/pdm_sinc_decimator_fir_core.sv @@
// Steps from the input beat to the result: sinc accumulation of the 64 PDM
// bits, the 103 taps through the MAC, draining the MAC pipeline, and clamping
// and registering the sample.
// The input stays stalled until the sample is registered, so no new beat is
// taken before then; a result still held by the receiver stretches the final
// step by the length of that stall.
// Reset (synchronous, active low) clears control state and the delay line's valid bits.
module pdm_sinc_decimator_fir_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_pdm_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_pcm_sample
);
    typedef enum logic [1:0] {S_IDLE, S_SINC, S_MAC, S_DONE} t_state;

    t_state                           r_state;
    logic [psd_pkg::PDM_BITS-1:0]     r_bits;   // shift register, LSB first
    logic [psd_pkg::BIT_W-1:0]        r_bit_cnt;
    psd_pkg::t_word                   r_sum;
    // Delay line as a circular memory; valid bits give the zero reset value.
    psd_pkg::t_word                   r_mem [psd_pkg::TAPS];
    logic [psd_pkg::TAPS-1:0]         r_vld;
    logic [psd_pkg::TAP_W-1:0]        r_head;   // slot of newest sample
    logic [psd_pkg::TAP_W-1:0]        r_k;      // tap being read
    logic [psd_pkg::TAP_W-1:0]        r_addr;
    psd_pkg::t_word                   r_rd;
    logic                             r_rd_ok;
    logic signed [15:0]               r_coef;
    logic                             r_mac_en;
    logic signed [psd_pkg::ACC_W-1:0] r_acc;
    logic                             r_out_v;
    psd_pkg::t_word                   r_out;

    logic signed [psd_pkg::ACC_W-1:0] w_prod;
    logic [psd_pkg::TAP_W-1:0]        n_head;
    logic [psd_pkg::TAP_W-1:0]        w_addr_nx;
    logic [psd_pkg::ACC_W-1:0]        w_shift;

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_out_v;
    assign o_pcm_sample = r_out;

    // Product of the registered tap and coefficient, unsigned data.
    assign w_prod = psd_pkg::ACC_W'(r_coef) * $signed({1'b0, r_rd});

    assign n_head = (r_head == '0) ? psd_pkg::TAP_W'(psd_pkg::TAPS - 1) : r_head - 1'b1;
    // Walk from newest towards oldest, wrapping around.
    assign w_addr_nx = (r_addr == psd_pkg::TAP_W'(psd_pkg::TAPS - 1)) ? '0 : r_addr + 1'b1;
    assign w_shift = psd_pkg::ACC_W'(r_acc >>> psd_pkg::FRAC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vld    <= '0;
            r_head   <= '0;
            r_out_v  <= 1'b0;
            r_mac_en <= 1'b0;
            r_rd_ok  <= 1'b0;
        end else begin
            // Drop the result once taken.
            if (r_out_v && !i_stall) r_out_v <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_bits    <= i_pdm_bits;
                        r_bit_cnt <= '0;
                        r_sum     <= '0;
                        r_state   <= S_SINC;
                    end
                end
                S_SINC: begin
                    // One PDM bit per cycle; the sum wraps at 16 bits.
                    if (r_bits[0]) r_sum <= r_sum + psd_pkg::sinc_coef(r_bit_cnt);
                    r_bits    <= r_bits >> 1;
                    r_bit_cnt <= r_bit_cnt + 1'b1;
                    if (r_bit_cnt == psd_pkg::BIT_W'(psd_pkg::PDM_BITS - 1)) begin
                        r_state <= S_MAC;
                        r_k     <= '0;
                        r_acc   <= '0;
                        r_head  <= n_head;
                        r_addr  <= n_head;
                    end
                end
                S_MAC: begin
                    // Newest sample lands in the head slot on the first tap.
                    if (r_k == '0) begin
                        r_mem[r_head] <= r_sum;
                        r_vld[r_head] <= 1'b1;
                        r_rd          <= r_sum;
                        r_rd_ok       <= 1'b1;
                    end else begin
                        r_rd    <= r_mem[r_addr];
                        r_rd_ok <= r_vld[r_addr];
                    end
                    r_coef   <= psd_pkg::fir_half(psd_pkg::coef_idx(r_k));
                    r_mac_en <= 1'b1;
                    r_addr   <= w_addr_nx;
                    r_k      <= r_k + 1'b1;
                    if (r_k == psd_pkg::TAP_W'(psd_pkg::TAPS - 1)) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_mac_en && !r_out_v) begin
                        if (r_acc <= 0) r_out <= '0;
                        else if (w_shift > psd_pkg::ACC_W'(16'hFFFF)) r_out <= 16'hFFFF;
                        else r_out <= w_shift[15:0];
                        r_out_v <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_mac_en) begin
                if (r_rd_ok) r_acc <= r_acc + w_prod;
                if (r_state != S_MAC) r_mac_en <= 1'b0;
            end
        end
    end
endmodule

@@ design/pdm_sinc_decimator_fir_core_chk.sv @@
module pdm_sinc_decimator_fir_core_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_pcm_sample
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pcm_sample))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not held off after a beat");
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> !$rose(o_valid))
        else $error("result too early");
endmodule

bind pdm_sinc_decimator_fir_core pdm_sinc_decimator_fir_core_chk u_chk (.*);
